// File: rtl/fmss_pkg.sv
// shared types, constants and helpers of the fm seek and station memory block
`timescale 1ns / 1ps
package fmss_pkg;

	// map and position geometry
	localparam int MAP_WORDS_DEF = 13;
	localparam int WORD_W        = 16;
	localparam int BIT_W         = 4;
	localparam int POPC_W        = 5;
	localparam int POS_W         = 8;
	localparam int CNT_W         = 8;
	localparam int KEY_W         = 11;
	localparam int FREQ_W        = 14;
	localparam int F100_W        = 11;
	localparam int LIMIT_W       = 8;

	// band in 100 kHz steps relative to 87.5 MHz
	localparam logic [POS_W-1:0]   POS_MAX     = 8'd205;
	localparam logic [KEY_W-1:0]   KEY_MIN     = 11'd875;
	localparam logic [KEY_W-1:0]   KEY_MAX     = 11'd1080;
	localparam logic [F100_W-1:0]  BASE_100K   = 11'd875;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd205;

	// command codes
	localparam logic [2:0] CMD_TICK    = 3'd0;
	localparam logic [2:0] CMD_SCAN    = 3'd1;
	localparam logic [2:0] CMD_HALF    = 3'd2;
	localparam logic [2:0] CMD_FSTEP   = 3'd3;
	localparam logic [2:0] CMD_CSTEP   = 3'd4;
	localparam logic [2:0] CMD_KEYPAD  = 3'd5;

	// operating modes
	localparam logic [1:0] MODE_PLAY = 2'd0;
	localparam logic [1:0] MODE_SCAN = 2'd1;
	localparam logic [1:0] MODE_HALF = 2'd2;

	// map write request
	typedef struct packed {
		logic             clear;
		logic             mark;
		logic [POS_W-1:0] pos;
	} fmss_map_wr_t;

	// lookup request and answer
	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] n;
	} fmss_srch_req_t;

	typedef struct packed {
		logic             done;
		logic             found;
		logic [POS_W-1:0] pos;
	} fmss_srch_rsp_t;

	function automatic logic [POPC_W-1:0] popcount16(input logic [WORD_W-1:0] w);
		logic [1:0]        p [WORD_W/2];
		logic [POPC_W-1:0] s;
		for (int i = 0; i < WORD_W/2; i++) begin
			p[i] = {1'b0, w[2*i]} + {1'b0, w[2*i+1]};
		end
		s = '0;
		for (int i = 0; i < WORD_W/2; i++) begin
			s = s + POPC_W'(p[i]);
		end
		return s;
	endfunction

endpackage

// File: rtl/fm_seek_station_memory.sv
// top level of the fm seek and station memory controller
//
//  port group   dir  handshake                 beat contents
//  ----------   ---  ------------------------  ---------------------------------------
//  in           in   in_valid / in_stall       command, station_found, direction, number
//  out          out  out_valid / out_stall     frequency, channel, station_total, mode,
//                                              retune, seek_finished
//  apb          in   psel/penable/pwrite/pready half_seek_limit at byte address 0
//
//  one item at a time: a beat that needs no station lookup goes from accept
//  through ST_EMIT to the result register. a channel step, a keypad channel
//  or the end of a scan with stations stored runs the lookup unit in ST_SEARCH,
//  which skips whole map words by count and then walks the bits of the hit word.
//  the lookup pace is set by the serial bit walk of one 16-bit map word.
//  reset clears the map and all control state at once; no clearing pass.
//  a stall on out holds the result register; in_stall stays high until the
//  result of the current beat is in the result register.
`timescale 1ns / 1ps
module fm_seek_station_memory
	import fmss_pkg::*;
#(
	parameter int MAP_WORDS = MAP_WORDS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// input beats
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         command,
	input  logic               station_found,
	input  logic               direction,
	input  logic [KEY_W-1:0]   number,
	// result beats
	output logic               out_valid,
	input  logic               out_stall,
	output logic [FREQ_W-1:0]  frequency,
	output logic [CNT_W-1:0]   channel,
	output logic [CNT_W-1:0]   station_total,
	output logic [1:0]         mode,
	output logic               retune,
	output logic               seek_finished,
	// configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int WIDX_W = $clog2(MAP_WORDS);

	// controller states
	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SEARCH = 2'd1;
	localparam logic [1:0] ST_EMIT   = 2'd2;

	logic [1:0]         state_q;
	logic [POS_W-1:0]   pos_q;        // tuned frequency as 100 kHz offset from 87.5 MHz
	logic [CNT_W-1:0]   chan_q;
	logic [CNT_W-1:0]   count_q;
	logic [1:0]         mode_q;
	logic               seek_up_q;
	logic [CNT_W-1:0]   attempt_q;
	logic [LIMIT_W-1:0] limit_q;
	logic               retune_q;
	logic               finish_q;

	// result register
	logic               out_valid_q;
	logic [FREQ_W-1:0]  frequency_q;
	logic [CNT_W-1:0]   channel_q;
	logic [CNT_W-1:0]   total_q;
	logic [1:0]         mode_out_q;
	logic               retune_out_q;
	logic               finish_out_q;

	logic               accept;
	logic               load_out;
	logic               cfg_wr;

	// next-state decode of one beat
	logic [POS_W-1:0]   pos_d;
	logic [CNT_W-1:0]   chan_d;
	logic [CNT_W-1:0]   count_d;
	logic [1:0]         mode_d;
	logic               seek_up_d;
	logic [CNT_W-1:0]   attempt_d;
	logic               retune_d;
	logic               finish_d;
	logic               srch_d;
	logic [CNT_W-1:0]   srch_n;
	logic [CNT_W-1:0]   cnt_inc;
	logic [CNT_W:0]     att_next;
	logic [POS_W-1:0]   pos_step;

	fmss_map_wr_t       map_wr;
	fmss_srch_req_t     srch_req;
	fmss_srch_rsp_t     srch_rsp;
	logic [WIDX_W-1:0]  rd_idx;
	logic [WORD_W-1:0]  rd_word;
	logic [F100_W-1:0]  f100;

	// one 100 kHz step with wrap at the band edges
	function automatic logic [POS_W-1:0] step_pos(input logic [POS_W-1:0] p, input logic up);
		logic [POS_W-1:0] r;
		if (up) begin
			r = (p >= POS_MAX) ? '0 : p + POS_W'(1);
		end else begin
			r = (p == '0) ? POS_MAX : p - POS_W'(1);
		end
		return r;
	endfunction

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign load_out = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);

	// step direction differs: a tick steps with the stored seek direction
	assign pos_step = step_pos(pos_q, (command == CMD_TICK) ? seek_up_q : direction);

	always_comb begin
		pos_d     = pos_q;
		chan_d    = chan_q;
		count_d   = count_q;
		mode_d    = mode_q;
		seek_up_d = seek_up_q;
		attempt_d = attempt_q;
		retune_d  = 1'b0;
		finish_d  = 1'b0;
		srch_d    = 1'b0;
		srch_n    = chan_q;
		map_wr    = '0;
		cnt_inc   = (count_q == '1) ? count_q : count_q + CNT_W'(1);
		att_next  = {1'b0, attempt_q} + (CNT_W+1)'(1);
		case (command)
			CMD_SCAN: begin
				// restarts from any mode
				map_wr.clear = 1'b1;
				count_d      = '0;
				chan_d       = CNT_W'(1);
				pos_d        = '0;
				mode_d       = MODE_SCAN;
			end
			CMD_TICK: begin
				case (mode_q)
					MODE_SCAN: begin
						if (station_found) begin
							count_d    = cnt_inc;
							chan_d     = cnt_inc;
							map_wr.mark = 1'b1;
							map_wr.pos = pos_q;
							retune_d   = 1'b1;
						end
						if (pos_q >= POS_MAX) begin
							// last step of the band ends the scan
							mode_d   = MODE_PLAY;
							pos_d    = '0;
							retune_d = 1'b1;
							finish_d = 1'b1;
							if (count_d != '0) begin
								chan_d = CNT_W'(1);
								srch_d = 1'b1;
								srch_n = CNT_W'(1);
							end
						end else begin
							pos_d = pos_q + POS_W'(1);
						end
					end
					MODE_HALF: begin
						if (station_found) begin
							mode_d   = MODE_PLAY;
							retune_d = 1'b1;
							finish_d = 1'b1;
						end else begin
							pos_d     = pos_step;
							attempt_d = att_next[CNT_W] ? '1 : att_next[CNT_W-1:0];
							if (att_next > {1'b0, limit_q}) begin
								mode_d   = MODE_PLAY;
								retune_d = 1'b1;
								finish_d = 1'b1;
							end
						end
					end
					default: begin
					end
				endcase
			end
			CMD_HALF: begin
				if (mode_q == MODE_PLAY) begin
					// first step is taken silently, tuner set only when the seek stops
					seek_up_d = direction;
					attempt_d = '0;
					pos_d     = pos_step;
					mode_d    = MODE_HALF;
				end
			end
			CMD_FSTEP: begin
				if (mode_q == MODE_PLAY) begin
					pos_d    = pos_step;
					retune_d = 1'b1;
				end
			end
			CMD_CSTEP: begin
				if (mode_q == MODE_PLAY && count_q != '0) begin
					if (direction) begin
						chan_d = (chan_q >= count_q) ? CNT_W'(1) : chan_q + CNT_W'(1);
					end else begin
						chan_d = (chan_q <= CNT_W'(1) || chan_q > count_q) ?
						         count_q : chan_q - CNT_W'(1);
					end
					srch_d   = 1'b1;
					srch_n   = chan_d;
					retune_d = 1'b1;
				end
			end
			CMD_KEYPAD: begin
				if (mode_q == MODE_PLAY) begin
					if (number != '0 && number <= {{(KEY_W-CNT_W){1'b0}}, count_q}) begin
						// channel number
						chan_d   = number[CNT_W-1:0];
						srch_d   = 1'b1;
						srch_n   = number[CNT_W-1:0];
						retune_d = 1'b1;
					end else if (number >= KEY_MIN && number <= KEY_MAX) begin
						// frequency in 100 kHz units
						pos_d    = POS_W'(number - KEY_MIN);
						retune_d = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		// the map only changes on an accepted beat
		if (!accept) begin
			map_wr = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pos_q     <= '0;
			chan_q    <= CNT_W'(1);
			count_q   <= '0;
			mode_q    <= MODE_PLAY;
			seek_up_q <= 1'b0;
			attempt_q <= '0;
			retune_q  <= 1'b0;
			finish_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						pos_q     <= pos_d;
						chan_q    <= chan_d;
						count_q   <= count_d;
						mode_q    <= mode_d;
						seek_up_q <= seek_up_d;
						attempt_q <= attempt_d;
						retune_q  <= retune_d;
						finish_q  <= finish_d;
						state_q   <= srch_d ? ST_SEARCH : ST_EMIT;
					end
				end
				ST_SEARCH: begin
					if (srch_rsp.done) begin
						// a missing station falls back to the band start
						pos_q   <= srch_rsp.found ? srch_rsp.pos : '0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// map and lookup unit
	assign srch_req.start = accept && srch_d;
	assign srch_req.n     = srch_n;

	fmss_map #(
		.MAP_WORDS(MAP_WORDS)
	) u_map (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (map_wr),
		.rd_idx (rd_idx),
		.rd_word(rd_word)
	);

	fmss_nth #(
		.MAP_WORDS(MAP_WORDS)
	) u_nth (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (srch_req),
		.rd_idx (rd_idx),
		.rd_word(rd_word),
		.rsp    (srch_rsp)
	);

	// frequency in 10 kHz units: (pos + 875) * 10
	assign f100 = F100_W'(pos_q) + BASE_100K;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			frequency_q  <= FREQ_W'({f100, 3'b000}) + FREQ_W'({f100, 1'b0});
			channel_q    <= chan_q;
			total_q      <= count_q;
			mode_out_q   <= mode_q;
			retune_out_q <= retune_q;
			finish_out_q <= finish_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign frequency     = frequency_q;
	assign channel       = channel_q;
	assign station_total = total_q;
	assign mode          = mode_out_q;
	assign retune        = retune_out_q;
	assign seek_finished = finish_out_q;

	// configuration register, word 0 only
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_wr && !paddr[2]) begin
			limit_q <= pwdata[LIMIT_W-1:0];
		end
	end

	assign prdata = paddr[2] ? 32'd0 : {{(32-LIMIT_W){1'b0}}, limit_q};

endmodule

// File: rtl/fmss_map.sv
// station map storage: one bit per 100 kHz position, cleared at scan start
`timescale 1ns / 1ps
module fmss_map
	import fmss_pkg::*;
#(
	parameter int MAP_WORDS = MAP_WORDS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  fmss_map_wr_t                 wr,
	input  logic [$clog2(MAP_WORDS)-1:0] rd_idx,
	output logic [WORD_W-1:0]            rd_word
);

	localparam int WIDX_W = $clog2(MAP_WORDS);

	logic [WORD_W-1:0] words_q [MAP_WORDS];
	logic              in_map;

	// positions past the last word are counted but never stored
	assign in_map = {{(POS_W-BIT_W){1'b0}}, wr.pos[POS_W-1:BIT_W]} < POS_W'(MAP_WORDS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAP_WORDS; i++) begin
				words_q[i] <= '0;
			end
		end else if (wr.clear) begin
			for (int i = 0; i < MAP_WORDS; i++) begin
				words_q[i] <= '0;
			end
		end else if (wr.mark && in_map) begin
			words_q[wr.pos[BIT_W+WIDX_W-1:BIT_W]][wr.pos[BIT_W-1:0]] <= 1'b1;
		end
	end

	assign rd_word = words_q[rd_idx];

endmodule

// File: rtl/fmss_nth.sv
// finds the nth set map bit: skips whole words by count, then walks bits serially
`timescale 1ns / 1ps
module fmss_nth
	import fmss_pkg::*;
#(
	parameter int MAP_WORDS = MAP_WORDS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  fmss_srch_req_t               req,
	output logic [$clog2(MAP_WORDS)-1:0] rd_idx,
	input  logic [WORD_W-1:0]            rd_word,
	output fmss_srch_rsp_t               rsp
);

	localparam int WIDX_W = $clog2(MAP_WORDS);
	localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(MAP_WORDS - 1);

	logic              busy_q;
	logic              bit_phase_q;
	logic [WIDX_W-1:0] widx_q;
	logic [CNT_W-1:0]  rem_q;
	logic [WORD_W-1:0] sr_q;
	logic [BIT_W-1:0]  bit_q;
	logic              done_q;
	logic              found_q;
	logic [POS_W-1:0]  pos_q;
	logic [CNT_W-1:0]  pc;

	assign pc     = CNT_W'(popcount16(rd_word));
	assign rd_idx = widx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			bit_phase_q <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q      <= 1'b1;
				bit_phase_q <= 1'b0;
			end else if (busy_q && !bit_phase_q) begin
				if (pc >= rem_q) begin
					bit_phase_q <= 1'b1;
				end else if (widx_q == LAST_WORD) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (busy_q) begin
				if ((sr_q[0] && rem_q == CNT_W'(1)) || bit_q == '1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			widx_q  <= '0;
			rem_q   <= req.n;
			found_q <= 1'b0;
		end else if (busy_q && !bit_phase_q) begin
			if (pc >= rem_q) begin
				// hit lies in this word
				sr_q  <= rd_word;
				bit_q <= '0;
			end else begin
				rem_q <= rem_q - pc;
				if (widx_q != LAST_WORD) begin
					widx_q <= widx_q + WIDX_W'(1);
				end
			end
		end else if (busy_q) begin
			if (sr_q[0]) begin
				if (rem_q == CNT_W'(1)) begin
					found_q <= 1'b1;
					pos_q   <= POS_W'({widx_q, bit_q});
				end else begin
					rem_q <= rem_q - CNT_W'(1);
				end
			end
			sr_q  <= sr_q >> 1;
			bit_q <= bit_q + BIT_W'(1);
		end
	end

	assign rsp.done  = done_q;
	assign rsp.found = found_q;
	assign rsp.pos   = pos_q;

endmodule
